[rtl/random_pick_value_pool_defines.svh]
// assertion helpers shared by the pool rtl
`ifndef RANDOM_PICK_VALUE_POOL_DEFINES_SVH
`define RANDOM_PICK_VALUE_POOL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RPVP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RPVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rpvp_pkg.sv]
package rpvp_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PICK_W = 16;
  localparam int unsigned LEFT_W = 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT      = 3'd0;
  localparam logic [OP_W-1:0] OP_PULL     = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL     = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] operand;
    logic [PICK_W-1:0]       rand_pick;
  } rpvp_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pulled;
    logic                    found;
    logic [LEFT_W-1:0]       entries_left;
    logic                    dropped;
  } rpvp_out_t;

endpackage

[rtl/rpvp_mod.sv]
module rpvp_mod #(
  parameter int unsigned CNT_W = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rpvp_pkg::PICK_W-1:0]    dividend_i,
  input  logic [CNT_W-1:0]               divisor_i,
  output logic                           done_o,
  output logic [CNT_W-1:0]               rem_o
);
  import rpvp_pkg::*;

  localparam int unsigned STEP_W = $clog2(PICK_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [PICK_W-1:0] dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W-1:0]  rem_d;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_q, dvd_q[PICK_W-1]};
    ge    = trial >= {1'b0, divisor_i};
    rem_d = ge ? CNT_W'(trial - {1'b0, divisor_i}) : trial[CNT_W-1:0];
  end

  assign done_o = busy_q && (step_q == STEP_W'(PICK_W - 1));
  assign rem_o  = rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      dvd_q  <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_q << 1;
      step_q <= step_q + STEP_W'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/random_pick_value_pool.sv]
// Unordered pool of up to CAPACITY signed 32-bit values kept in one simple dual-port
// synchronous memory (one write and one registered read per cycle) plus an entry
// count. Each input transaction gives exactly one result transaction. Put and the
// unused op codes go straight to the finish step, as do pull, contains and remove
// on an empty pool. Pull runs a 16-step remainder unit that reduces rand_pick by
// the count, then the picked slot and the last slot are read one after the other
// through the memory port and the last value is written back into the hole.
// Contains scans the memory one entry a cycle. Remove adds a read of the last slot
// and a write-back after a hit. Fill writes one entry per cycle. A new transaction
// is taken while the previous result still waits in the output register; only
// the finish step waits for it.
`include "random_pick_value_pool_defines.svh"

module random_pick_value_pool #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rpvp_pkg::rpvp_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rpvp_pkg::rpvp_out_t  out_data_o
);
  import rpvp_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);       // memory index
  localparam int unsigned CW = $clog2(CAPACITY + 1);   // count, holds CAPACITY itself
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_WB,
    ST_SCAN,
    ST_FILL,
    ST_FINISH
  } st_e;

  st_e                     state_q;
  logic [CW-1:0]           count_q;
  logic [OP_W-1:0]         op_q;
  logic [VAL_W-1:0]        val_q;
  logic [IW-1:0]           idx_q;
  logic [CW-1:0]           scan_q;
  logic                    pend_q;
  logic [IW-1:0]           pidx_q;
  logic [CW-1:0]           fill_q;
  logic [CW-1:0]           lim_q;
  logic signed [VAL_W-1:0] res_pulled_q;
  logic                    res_found_q;
  logic                    res_dropped_q;
  logic                    out_valid_q;
  rpvp_out_t               out_q;

  // entry memory, one write and one registered read per cycle
  logic [VAL_W-1:0]        entry_mem [CAPACITY];
  logic [VAL_W-1:0]        rd_data_q;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [VAL_W-1:0]        mem_wdata;
  logic [IW-1:0]           rd_addr;

  logic                    out_free;
  logic                    accept;
  logic [CW-1:0]           last_w;
  logic [CW-1:0]           fill_lim;
  logic                    hit;
  logic                    scan_last;
  logic                    div_start;
  logic                    div_done;
  logic [CW-1:0]           div_rem;

  // output register frees when empty or being taken this cycle
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) || ((state_q == ST_FINISH) && out_free));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // slot of the last entry, only used while count is nonzero
  assign last_w = count_q - CW'(1);

  // fill count: negative empties the pool, large values clip to capacity
  always_comb begin
    if (in_data_i.operand[VAL_W-1]) begin
      fill_lim = '0;
    end else if ($unsigned(in_data_i.operand) > VAL_W'(CAPACITY)) begin
      fill_lim = CAP_C;
    end else begin
      fill_lim = in_data_i.operand[CW-1:0];
    end
  end

  // scan compares the entry read in the previous cycle
  assign hit       = pend_q && (rd_data_q == val_q);
  assign scan_last = pend_q && (pidx_q == last_w[IW-1:0]);

  assign div_start = accept && (in_data_i.op == OP_PULL) && (count_q != '0);

  // remainder unit for rand_pick mod count; count is stable while it runs
  rpvp_mod #(
    .CNT_W (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.rand_pick),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IW-1:0];
    mem_wdata = in_data_i.operand;
    rd_addr   = idx_q;
    // put writes the append slot in the accepting cycle
    if (accept && (in_data_i.op == OP_PUT) && (count_q < CAP_C)) begin
      mem_we = 1'b1;
    end
    unique case (state_q)
      ST_WB: begin
        // last entry moves into the hole
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
      end
      ST_FILL: begin
        if (fill_q < lim_q) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[IW-1:0];
          mem_wdata = VAL_W'(fill_q);
        end
      end
      ST_SCAN: rd_addr = scan_q[IW-1:0];
      ST_RD_B: rd_addr = last_w[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= entry_mem[rd_addr];
  end

  // sequencer, count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      op_q          <= OP_PUT;
      val_q         <= '0;
      idx_q         <= '0;
      scan_q        <= '0;
      pend_q        <= 1'b0;
      pidx_q        <= '0;
      fill_q        <= '0;
      lim_q         <= '0;
      res_pulled_q  <= '0;
      res_found_q   <= 1'b0;
      res_dropped_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // result register loads from the finish step, clears when taken
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: ;
        ST_DIV: begin
          if (div_done) begin
            idx_q   <= div_rem[IW-1:0];
            state_q <= ST_RD_A;
          end
        end
        ST_RD_A: state_q <= ST_RD_B;
        ST_RD_B: begin
          // picked entry arrives here for pull
          if (op_q == OP_PULL) begin
            res_pulled_q <= rd_data_q;
          end
          state_q <= ST_WB;
        end
        ST_WB: begin
          count_q <= count_q - CW'(1);
          state_q <= ST_FINISH;
        end
        ST_SCAN: begin
          pend_q <= scan_q < count_q;
          pidx_q <= scan_q[IW-1:0];
          scan_q <= scan_q + CW'(1);
          if (hit) begin
            res_found_q <= 1'b1;
            if (op_q == OP_REMOVE) begin
              idx_q   <= pidx_q;
              state_q <= ST_RD_B;
            end else begin
              state_q <= ST_FINISH;
            end
          end else if (scan_last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FILL: begin
          if (fill_q < lim_q) begin
            fill_q <= fill_q + CW'(1);
          end else begin
            count_q <= lim_q;
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q.pulled        <= res_pulled_q;
            out_q.found         <= res_found_q;
            out_q.entries_left  <= LEFT_W'(count_q);
            out_q.dropped       <= res_dropped_q;
            // a transaction taken in this cycle picks the next state below
            if (!accept) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // new transaction, also taken in the finish cycle
      if (accept) begin
        op_q          <= in_data_i.op;
        val_q         <= in_data_i.operand;
        res_pulled_q  <= '0;
        res_found_q   <= 1'b0;
        res_dropped_q <= 1'b0;
        scan_q        <= '0;
        pend_q        <= 1'b0;
        fill_q        <= '0;
        lim_q         <= fill_lim;
        unique case (in_data_i.op)
          OP_PUT: begin
            if (count_q < CAP_C) begin
              count_q <= count_q + CW'(1);
            end else begin
              res_dropped_q <= 1'b1;
            end
            state_q <= ST_FINISH;
          end
          OP_PULL: state_q <= (count_q != '0) ? ST_DIV : ST_FINISH;
          OP_CONTAINS, OP_REMOVE: state_q <= (count_q != '0) ? ST_SCAN : ST_FINISH;
          OP_FILL: state_q <= ST_FILL;
          default: state_q <= ST_FINISH;
        endcase
      end
    end
  end

  `RPVP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_C, "pool count above capacity")
  `RPVP_ASSERT_NOW(a_rem_below_count, div_done, div_rem < count_q, "pick index not below count")
  `RPVP_ASSERT_NEXT(a_wb_shrinks, state_q == ST_WB, count_q == $past(count_q) - CW'(1), "write-back did not shrink pool")
  `RPVP_ASSERT_NOW(a_put_room, mem_we && state_q != ST_WB && state_q != ST_FILL, count_q < CAP_C, "append into full pool")
  `RPVP_ASSERT_NEXT(a_out_from_finish, !out_valid_q && state_q != ST_FINISH, !out_valid_q, "result shown outside finish step")

endmodule

[tb/random_pick_value_pool_test.sv]
module random_pick_value_pool_test;
  import rpvp_pkg::*;

  // pool size the block is built with
  localparam int POOL_CAP = 256;

  // op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // clock, reset and the two channels, all known from time zero
  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  rpvp_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  rpvp_out_t out_data_o;

  // shadow copy of the pool, advanced at each accepted input transaction
  logic signed [VAL_W-1:0] pool_vals [POOL_CAP];
  int unsigned             pool_len = 0;

  // results still owed by the block, oldest first
  rpvp_out_t pending_results [$];

  // idling knobs shared by sender, receiver and the tests
  bit sender_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int hold_request = 0;

  // bookkeeping for the verdict and the closing summary
  int failures = 0;
  int results_checked = 0;
  int ops_sent [8];
  int drops_seen = 0;
  int hits_seen = 0;

  random_pick_value_pool #(
    .CAPACITY(POOL_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // idle stretch: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // lowest index holding v, or the pool length when absent
  function automatic int unsigned pool_index_of(input logic signed [VAL_W-1:0] v);
    for (int unsigned i = 0; i < pool_len; i++) begin
      if (pool_vals[i] == v) return i;
    end
    return pool_len;
  endfunction

  // apply one operation to the shadow pool and return the result it owes
  function automatic rpvp_out_t pool_apply(input rpvp_in_t t);
    rpvp_out_t   r;
    int unsigned idx;
    int unsigned n;
    int          v;
    r = '0;
    case (t.op)
      OP_PUT: begin
        if (pool_len < POOL_CAP) begin
          pool_vals[pool_len] = t.operand;
          pool_len++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      OP_PULL: begin
        // the last entry fills the hole left by the picked one
        if (pool_len != 0) begin
          idx = t.rand_pick % pool_len;
          r.pulled = pool_vals[idx];
          pool_len--;
          pool_vals[idx] = pool_vals[pool_len];
        end
      end
      OP_CONTAINS: begin
        r.found = (pool_index_of(t.operand) < pool_len);
      end
      OP_REMOVE: begin
        idx = pool_index_of(t.operand);
        if (idx < pool_len) begin
          pool_len--;
          pool_vals[idx] = pool_vals[pool_len];
          r.found = 1'b1;
        end
      end
      OP_FILL: begin
        // negative counts empty the pool, large ones clip to capacity
        v = t.operand;
        if (v < 0) n = 0;
        else if (v > POOL_CAP) n = POOL_CAP;
        else n = v;
        for (int unsigned i = 0; i < n; i++) pool_vals[i] = i;
        pool_len = n;
      end
      default: ;
    endcase
    r.entries_left = LEFT_W'(pool_len);
    return r;
  endfunction

  // offer one input transaction after a random gap, hold it until taken
  task automatic offer_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] operand,
                          input logic [PICK_W-1:0] pick);
    rpvp_in_t  item;
    rpvp_out_t owed;
    int        gap;
    item.op = op;
    item.operand = operand;
    item.rand_pick = pick;
    gap = sender_idle_on ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    // accepted on this edge: predict right away so the shadow pool stays current
    owed = pool_apply(item);
    pending_results.push_back(owed);
    ops_sent[op]++;
    if (owed.dropped) drops_seen++;
    if (owed.found) hits_seen++;
  endtask

  // sender goes quiet until the block has handed back everything it owes
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // pull, contains and remove against an empty pool
  task automatic test_empty_pool();
    offer_op(OP_PULL, 32'h0000_0000, 16'hFFFF);
    offer_op(OP_CONTAINS, 32'h0000_0000, 16'h0000);
    offer_op(OP_REMOVE, 32'h0000_0000, 16'h0000);
  endtask

  // fill counts below zero, above and at capacity, then a put, searches and a pull on a full pool
  task automatic test_fill_limits();
    offer_op(OP_FILL, 32'hFFFF_FFFF, 16'h0000);
    offer_op(OP_FILL, 32'h8000_0000, 16'hFFFF);
    offer_op(OP_FILL, 32'd257, 16'h0000);
    offer_op(OP_PUT, 32'd42, 16'h0000);
    offer_op(OP_FILL, 32'h7FFF_FFFF, 16'h0000);
    offer_op(OP_CONTAINS, 32'd255, 16'h0000);
    offer_op(OP_REMOVE, 32'd256, 16'h0000);
    offer_op(OP_FILL, 32'd256, 16'h0000);
    offer_op(OP_PULL, 32'h0000_0000, 16'hFFFF);
  endtask

  // extreme values and duplicates: searches must act on the lowest match
  task automatic test_duplicates();
    offer_op(OP_FILL, 32'd0, 16'h0000);
    offer_op(OP_PUT, 32'h7FFF_FFFF, 16'h0000);
    offer_op(OP_PUT, 32'h8000_0000, 16'h0000);
    offer_op(OP_PUT, 32'hFFFF_FFFF, 16'h0000);
    offer_op(OP_PUT, 32'h7FFF_FFFF, 16'h0000);
    offer_op(OP_REMOVE, 32'h7FFF_FFFF, 16'h0000);
    offer_op(OP_CONTAINS, 32'h7FFF_FFFF, 16'h0000);
    offer_op(OP_REMOVE, 32'd12345, 16'h0000);
    offer_op(OP_PULL, 32'h0000_0000, 16'hFFFF);
    offer_op(OP_PULL, 32'h0000_0000, 16'h0000);
  endtask

  // unused op codes leave the pool alone and report only the count
  task automatic test_unused_ops();
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) begin
      offer_op(OP_W'(c), $urandom, PICK_W'($urandom_range(0, 65535)));
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_hold();
    sender_idle_on = 1'b0;
    hold_request = 400;
    repeat (6) offer_op(OP_PUT, $urandom, PICK_W'($urandom_range(0, 65535)));
    offer_op(OP_PULL, 32'h0000_0000, PICK_W'($urandom_range(0, 65535)));
    offer_op(OP_CONTAINS, 32'd3, 16'h0000);
    sender_idle_on = 1'b1;
  endtask

  // fill then a burst of random operations, with a little noise mixed in
  task automatic test_random_sequences(input int target);
    int               start_count;
    int               r;
    int               body_len;
    logic [VAL_W-1:0] value;
    logic [OP_W-1:0]  op;
    start_count = results_checked + pending_results.size();
    while (results_checked + pending_results.size() - start_count < target) begin
      // some sequences run with no idling on one side or the other
      sender_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) value = $urandom_range(0, 24);
      else if (r < 85) value = $urandom_range(25, 255);
      else if (r < 93) value = POOL_CAP;
      else value = $urandom;
      offer_op(OP_FILL, value, PICK_W'($urandom_range(0, 65535)));
      body_len = $urandom_range(4, 30);
      repeat (body_len) begin
        // operands lean toward values that are likely in the pool
        r = $urandom_range(0, 9);
        if (r < 5) value = $urandom_range(0, 15);
        else if (r < 7 && pool_len != 0) value = pool_vals[$urandom_range(0, pool_len - 1)];
        else value = $urandom;
        r = $urandom_range(0, 99);
        if (r < 30) op = OP_PUT;
        else if (r < 55) op = OP_PULL;
        else if (r < 72) op = OP_CONTAINS;
        else if (r < 92) op = OP_REMOVE;
        else if (r < 96) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else op = OP_FILL;
        offer_op(op, value, PICK_W'($urandom_range(0, 65535)));
      end
    end
    sender_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // receiver: random stalls, plus a long hold counted here when a test asks
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (recv_idle_on) stall_left = idle_len();
      end
    end
  end

  // field compare with a report on mismatch
  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // checker: each result transaction against the oldest expectation
  initial begin
    rpvp_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          failures++;
          $display("%0t: result with nothing expected, actual %p", $time, out_data_o);
        end else begin
          want = pending_results.pop_front();
          check_field("pulled", want.pulled, out_data_o.pulled);
          check_field("found", want.found, out_data_o.found);
          check_field("entries_left", want.entries_left, out_data_o.entries_left);
          check_field("dropped", want.dropped, out_data_o.dropped);
          results_checked++;
        end
      end
    end
  end

  // hard limit on the run
  initial begin
    #30_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_pool();
    wait_drained();
    test_fill_limits();
    wait_drained();
    test_duplicates();
    test_unused_ops();
    wait_drained();
    test_output_hold();
    wait_drained();
    test_random_sequences(1575);
    wait_drained();
    // longest op is a full-pool search, so give stray results time to show
    repeat (300) @(posedge clk_i);
    $display("checked %0d results: %0d put, %0d pull, %0d contains, %0d remove, %0d fill",
             results_checked, ops_sent[OP_PUT], ops_sent[OP_PULL], ops_sent[OP_CONTAINS],
             ops_sent[OP_REMOVE], ops_sent[OP_FILL]);
    $display("%0d unused codes, %0d puts dropped on a full pool, %0d search hits",
             ops_sent[5] + ops_sent[6] + ops_sent[7], drops_seen, hits_seen);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
